>>> hdl/qct_pkg.sv
// Shared types and character codes for the quoted command tokenizer.
// No dependencies; included by every module of the block by wildcard import.
package qct_pkg;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last;
  } qct_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       word_start;
    logic [7:0] word_count;
    logic       unterminated;
  } qct_out_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

>>> hdl/qct_core.sv
// Tokenizer state registers and the per-word next-state and result logic.
// Depends on qct_pkg for the word structs and character codes.
module qct_core
  import qct_pkg::*;
#(
  parameter int MAX_WORDS  = 255,
  parameter int DEPTH_BITS = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  qct_in_t  item,
  output qct_out_t result
);

  localparam logic [7:0] CountCap = (MAX_WORDS > 255) ? 8'd255 : 8'(MAX_WORDS);

  logic                  in_quote_r, in_quote_nxt;
  logic                  quote_dbl_r, quote_dbl_nxt;
  logic [DEPTH_BITS-1:0] depth_r, depth_nxt;
  logic                  pending_r, pending_nxt;
  logic [7:0]            words_r, words_nxt;

  logic [7:0] c;
  logic [7:0] ob;
  logic       ws;
  logic       touch;
  logic       un;
  logic [7:0] closer;
  logic [7:0] words_tmp;

  assign c      = item.in_byte;
  assign closer = quote_dbl_r ? CH_DQUOTE : CH_SQUOTE;

  always_comb begin
    in_quote_nxt  = in_quote_r;
    quote_dbl_nxt = quote_dbl_r;
    depth_nxt     = depth_r;
    pending_nxt   = pending_r;
    ob            = c;
    touch         = 1'b0;

    if (!in_quote_r) begin
      if (is_blank(c)) begin
        ob          = CH_NUL;
        pending_nxt = 1'b1;
      end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
        ob            = CH_NUL;
        in_quote_nxt  = 1'b1;
        quote_dbl_nxt = (c == CH_DQUOTE);
        depth_nxt     = '0;
        pending_nxt   = 1'b1;
      end else begin
        touch = 1'b1;
      end
    end else begin
      if (depth_r == '0 && c == closer) begin
        ob           = CH_NUL;
        in_quote_nxt = 1'b0;
        pending_nxt  = 1'b1;
      end else begin
        touch = (depth_r == '0);
        if (c == CH_LBRACE) begin
          depth_nxt = depth_r + DEPTH_BITS'(1);
        end else if (c == CH_RBRACE) begin
          depth_nxt = depth_r - DEPTH_BITS'(1);
        end else if (c == CH_BSLASH) begin
          ob = CH_SPACE;
        end
      end
    end

    ws        = touch && pending_r;
    words_tmp = words_r;
    if (touch) begin
      pending_nxt = 1'b0;
    end
    if (ws && words_r < CountCap) begin
      words_tmp = words_r + 8'd1;
    end

    // An open quote on the final byte takes back one word, never below zero.
    un        = item.last && in_quote_nxt;
    words_nxt = words_tmp;
    if (un && words_tmp != 8'd0) begin
      words_nxt = words_tmp - 8'd1;
    end

    result.out_byte     = ob;
    result.word_start   = ws;
    result.word_count   = words_nxt;
    result.unterminated = un;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.last)) begin
      in_quote_r  <= 1'b0;
      quote_dbl_r <= 1'b0;
      depth_r     <= '0;
      pending_r   <= 1'b1;
      words_r     <= 8'd0;
    end else if (step) begin
      in_quote_r  <= in_quote_nxt;
      quote_dbl_r <= quote_dbl_nxt;
      depth_r     <= depth_nxt;
      pending_r   <= pending_nxt;
      words_r     <= words_nxt;
    end
  end

endmodule

>>> hdl/quoted_command_tokenizer_unit.sv
// Top level of the quoted command tokenizer: input register, tokenizer core,
// result register. Depends on qct_pkg and qct_core.
//
// Usage: a command line enters one character word at a time on the in_
// channel (in_valid/in_ready, payload in_word), with last set on the final
// character. Each accepted word yields exactly one result word on the out_
// channel (out_valid/out_ready, payload out_word): the rewritten character,
// a word-start mark, the running word count and, on the last character, an
// open-quote flag.
// A result passes through the input register, then the result register.
// Throughput: one character per cycle while out_ready stays high; the core
// updates its state as each character moves into the result register.
// When out_ready is low, the result register holds its word and the input
// register still takes one more character; in_ready then drops until the
// result is taken. in_ready depends combinationally on out_ready.
// Reset (rst_n low, synchronous) empties both registers and returns the
// tokenizer to its start-of-line state. The final character of a line also
// returns it to that state once its result is formed.
module quoted_command_tokenizer_unit
  import qct_pkg::*;
#(
  parameter int MAX_WORDS  = 255,
  parameter int DEPTH_BITS = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  qct_in_t  in_word,
  output logic     out_valid,
  input  logic     out_ready,
  output qct_out_t out_word
);

  logic     s1_valid_r, s1_valid_nxt;
  qct_in_t  s1_word_r;
  logic     out_valid_r, out_valid_nxt;
  qct_out_t out_word_r;
  qct_out_t core_result;
  logic     advance;
  logic     in_take;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_take  = in_valid && in_ready;

  qct_core #(
    .MAX_WORDS  (MAX_WORDS),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (s1_word_r),
    .result (core_result)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word_r <= in_word;
    end
    if (advance) begin
      out_word_r <= core_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

>>> hdl/qct_checker.sv
// Port-level checks for the quoted command tokenizer, bound to the top level.
// Depends on qct_pkg and quoted_command_tokenizer_unit.
module qct_checker
  import qct_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input qct_in_t  in_word,
  input logic     out_valid,
  input logic     out_ready,
  input qct_out_t out_word
);

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A word that starts is counted unless an open quote took it back.
  a_start_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.word_start && !out_word.unterminated
      |-> out_word.word_count != 8'd0)
    else $error("word start with zero count");

  // Nothing comes out of an idle block: a result needs an accepted word.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid) |-> $past(in_valid && in_ready, 2)
      || $past(!in_ready, 1))
    else $error("result without an accepted word");

endmodule

bind quoted_command_tokenizer_unit qct_checker u_qct_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);
